/* src/yuvrgb_pkg.sv */
// Package for the YUV 4:2:0 to RGB pixel pair converter.
// Holds coefficients, field widths, register indexes and shared types.
// No dependencies.
package yuvrgb_pkg;

  localparam int PIX_W    = 8;
  localparam int PROD_W   = 24;
  localparam int SUM_W    = 26;
  localparam int FRAC_W   = 13;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W    = $clog2(FIFO_DEPTH);
  localparam int CNT_W    = PTR_W + 1;

  localparam int COEF_Y   = 9539;
  localparam int COEF_RV  = 13075;
  localparam int COEF_GU  = 3209;
  localparam int COEF_GV  = 6660;
  localparam int COEF_BU  = 16525;
  localparam int Y_OFFSET = 'h10;
  localparam int C_OFFSET = 'h80;
  localparam int ROUND    = (1 << 12);

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [0:0] {
    REG_SMOOTH_ENABLE = 1'b0
  } reg_idx_t;

  // One pixel pair ready for color conversion.
  typedef struct packed {
    logic [PIX_W-1:0] luma_even;
    logic [PIX_W-1:0] luma_odd;
    logic [PIX_W-1:0] cb_even;
    logic [PIX_W-1:0] cr_even;
    logic [PIX_W-1:0] cb_odd;
    logic [PIX_W-1:0] cr_odd;
    logic             last;
  } job_t;

  typedef struct packed {
    logic vld;
    logic last;
  } job_ctrl_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

endpackage

/* src/yuvrgb_if.sv */
// Stream interfaces for the input pixel pairs and the RGB result pairs.
// Depends on yuvrgb_pkg.
interface yuvrgb_in_if;
  logic                         valid;
  logic                         ready;
  logic [yuvrgb_pkg::PIX_W-1:0] luma_even;
  logic [yuvrgb_pkg::PIX_W-1:0] luma_odd;
  logic [yuvrgb_pkg::PIX_W-1:0] cb_cur;
  logic [yuvrgb_pkg::PIX_W-1:0] cr_cur;
  logic [yuvrgb_pkg::PIX_W-1:0] cb_near;
  logic [yuvrgb_pkg::PIX_W-1:0] cr_near;
  logic                         row_end;

  modport source (
    output valid, luma_even, luma_odd, cb_cur, cr_cur, cb_near, cr_near, row_end,
    input  ready
  );
  modport sink (
    input  valid, luma_even, luma_odd, cb_cur, cr_cur, cb_near, cr_near, row_end,
    output ready
  );
endinterface

interface yuvrgb_out_if;
  logic                         valid;
  logic                         ready;
  logic [yuvrgb_pkg::PIX_W-1:0] red_even;
  logic [yuvrgb_pkg::PIX_W-1:0] green_even;
  logic [yuvrgb_pkg::PIX_W-1:0] blue_even;
  logic [yuvrgb_pkg::PIX_W-1:0] red_odd;
  logic [yuvrgb_pkg::PIX_W-1:0] green_odd;
  logic [yuvrgb_pkg::PIX_W-1:0] blue_odd;
  logic                         row_last;

  modport source (
    output valid, red_even, green_even, blue_even, red_odd, green_odd, blue_odd, row_last,
    input  ready
  );
  modport sink (
    input  valid, red_even, green_even, blue_even, red_odd, green_odd, blue_odd, row_last,
    output ready
  );
endinterface

/* src/yuvrgb_front.sv */
// Front end: holds the pending smooth pair, blends chroma and queues pair jobs.
// Depends on yuvrgb_pkg and yuvrgb_in_if.
module yuvrgb_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  smooth,
  yuvrgb_in_if.sink             in_ch,
  input  logic                  pop,
  output yuvrgb_pkg::job_t      head,
  output yuvrgb_pkg::job_ctrl_t head_ctrl
);

  localparam int W = yuvrgb_pkg::PIX_W;

  typedef struct packed {
    logic [W-1:0] cb;
    logic [W-1:0] cr;
    logic [W-1:0] cbn;
    logic [W-1:0] crn;
  } chroma_t;

  function automatic yuvrgb_pkg::job_t blend(input logic [W-1:0] ye, input logic [W-1:0] yo,
                                             input chroma_t c, input chroma_t n,
                                             input logic last);
    yuvrgb_pkg::job_t j;
    logic [W+1:0] ue;
    logic [W+1:0] ve;
    logic [W+2:0] uo;
    logic [W+2:0] vo;
    ue = 10'(c.cb) * 10'd3 + 10'(c.cbn) + 10'd2;
    ve = 10'(c.cr) * 10'd3 + 10'(c.crn) + 10'd2;
    uo = 11'(c.cb) * 11'd3 + 11'(n.cb) * 11'd3 + 11'(c.cbn) + 11'(n.cbn) + 11'd4;
    vo = 11'(c.cr) * 11'd3 + 11'(n.cr) * 11'd3 + 11'(c.crn) + 11'(n.crn) + 11'd4;
    j.luma_even = ye;
    j.luma_odd  = yo;
    j.cb_even   = ue[W+1:2];
    j.cr_even   = ve[W+1:2];
    j.cb_odd    = uo[W+2:3];
    j.cr_odd    = vo[W+2:3];
    j.last      = last;
    return j;
  endfunction

  yuvrgb_pkg::job_t fifo_r [yuvrgb_pkg::FIFO_DEPTH];
  logic [yuvrgb_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [yuvrgb_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [yuvrgb_pkg::CNT_W-1:0] count_r, count_nxt;

  logic          pend_vld_r, pend_vld_nxt;
  logic [W-1:0]  pend_ye_r, pend_yo_r;
  chroma_t       pend_c_r;

  chroma_t          cur;
  logic             in_fire;
  yuvrgb_pkg::job_t job_a, job_b, slot0, slot1;
  logic             has_a, has_b;
  logic [1:0]       n_wr;
  logic             do_pop;

  assign cur      = '{cb: in_ch.cb_cur, cr: in_ch.cr_cur, cbn: in_ch.cb_near,
                      crn: in_ch.cr_near};
  assign in_ch.ready = (count_r <= yuvrgb_pkg::CNT_W'(yuvrgb_pkg::FIFO_DEPTH - 2));
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign do_pop   = pop && (count_r != '0);

  always_comb begin
    has_a = pend_vld_r;
    if (smooth) begin
      job_a = blend(pend_ye_r, pend_yo_r, pend_c_r, cur, 1'b0);
      job_b = blend(in_ch.luma_even, in_ch.luma_odd, cur, cur, 1'b1);
      has_b = in_ch.row_end;
    end else begin
      job_a = blend(pend_ye_r, pend_yo_r, pend_c_r, pend_c_r, 1'b0);
      job_b = '{luma_even: in_ch.luma_even, luma_odd: in_ch.luma_odd,
                cb_even: in_ch.cb_cur, cr_even: in_ch.cr_cur,
                cb_odd: in_ch.cb_cur, cr_odd: in_ch.cr_cur, last: in_ch.row_end};
      has_b = 1'b1;
    end
    slot0 = has_a ? job_a : job_b;
    slot1 = job_b;
    n_wr  = in_fire ? (2'(has_a) + 2'(has_b)) : 2'd0;

    pend_vld_nxt = pend_vld_r;
    if (in_fire) begin
      pend_vld_nxt = smooth && !in_ch.row_end;
    end

    wr_ptr_nxt = wr_ptr_r + yuvrgb_pkg::PTR_W'(n_wr);
    rd_ptr_nxt = rd_ptr_r + yuvrgb_pkg::PTR_W'(do_pop);
    count_nxt  = count_r + yuvrgb_pkg::CNT_W'(n_wr) - yuvrgb_pkg::CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      count_r    <= count_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && smooth && !in_ch.row_end) begin
      pend_ye_r <= in_ch.luma_even;
      pend_yo_r <= in_ch.luma_odd;
      pend_c_r  <= cur;
    end
    if (n_wr != 2'd0) begin
      fifo_r[wr_ptr_r] <= slot0;
    end
    if (n_wr == 2'd2) begin
      fifo_r[wr_ptr_r + yuvrgb_pkg::PTR_W'(1)] <= slot1;
    end
  end

  assign head          = fifo_r[rd_ptr_r];
  assign head_ctrl.vld  = (count_r != '0);
  assign head_ctrl.last = head.last;

endmodule

/* src/yuvrgb_lane.sv */
// One pixel lane: BT.601 products in a first stage, sum, shift and clamp after.
// Depends on yuvrgb_pkg.
module yuvrgb_lane (
  input  logic                           clk,
  input  logic                           en,
  input  logic [yuvrgb_pkg::PIX_W-1:0]   y,
  input  logic [yuvrgb_pkg::PIX_W-1:0]   u,
  input  logic [yuvrgb_pkg::PIX_W-1:0]   v,
  output yuvrgb_pkg::rgb_t               rgb
);

  localparam int PW = yuvrgb_pkg::PROD_W;
  localparam int SW = yuvrgb_pkg::SUM_W;
  localparam int HW = SW - yuvrgb_pkg::FRAC_W;

  function automatic logic [yuvrgb_pkg::PIX_W-1:0] clamp(input logic signed [HW-1:0] x);
    logic [yuvrgb_pkg::PIX_W-1:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > HW'(255)) begin
      res = '1;
    end else begin
      res = x[yuvrgb_pkg::PIX_W-1:0];
    end
    return res;
  endfunction

  localparam int W9 = yuvrgb_pkg::PIX_W + 1;
  logic signed [W9-1:0] ys, us, vs;
  logic signed [PW-1:0] ys_e, us_e, vs_e;
  logic signed [PW-1:0] y_r, rv_r, gu_r, gv_r, bu_r;
  logic signed [SW-1:0] r_sum, g_sum, b_sum;

  assign ys   = $signed({1'b0, y}) - W9'(yuvrgb_pkg::Y_OFFSET);
  assign us   = $signed({1'b0, u}) - W9'(yuvrgb_pkg::C_OFFSET);
  assign vs   = $signed({1'b0, v}) - W9'(yuvrgb_pkg::C_OFFSET);
  assign ys_e = PW'(ys);
  assign us_e = PW'(us);
  assign vs_e = PW'(vs);

  always_ff @(posedge clk) begin
    if (en) begin
      y_r  <= ys_e * PW'(yuvrgb_pkg::COEF_Y);
      rv_r <= vs_e * PW'(yuvrgb_pkg::COEF_RV);
      gu_r <= us_e * PW'(yuvrgb_pkg::COEF_GU);
      gv_r <= vs_e * PW'(yuvrgb_pkg::COEF_GV);
      bu_r <= us_e * PW'(yuvrgb_pkg::COEF_BU);
    end
  end

  assign r_sum = SW'(y_r) + SW'(rv_r) + SW'(yuvrgb_pkg::ROUND);
  assign g_sum = SW'(y_r) - SW'(gu_r) - SW'(gv_r) + SW'(yuvrgb_pkg::ROUND);
  assign b_sum = SW'(y_r) + SW'(bu_r) + SW'(yuvrgb_pkg::ROUND);

  assign rgb.red   = clamp(HW'(r_sum >>> yuvrgb_pkg::FRAC_W));
  assign rgb.green = clamp(HW'(g_sum >>> yuvrgb_pkg::FRAC_W));
  assign rgb.blue  = clamp(HW'(b_sum >>> yuvrgb_pkg::FRAC_W));

endmodule

/* src/yuvrgb_merge.sv */
// Merge stage: tracks the lane pipeline and registers both lanes into one result pair.
// Depends on yuvrgb_pkg and yuvrgb_out_if.
module yuvrgb_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  yuvrgb_pkg::job_ctrl_t job_ctrl,
  input  yuvrgb_pkg::rgb_t      rgb_even,
  input  yuvrgb_pkg::rgb_t      rgb_odd,
  output logic                  adv,
  yuvrgb_out_if.source          out_ch
);

  logic v1_r, v1_nxt;
  logic last1_r;
  logic out_vld_r, out_vld_nxt;

  assign adv = !out_vld_r || out_ch.ready;

  always_comb begin
    v1_nxt      = v1_r;
    out_vld_nxt = out_vld_r;
    if (adv) begin
      v1_nxt      = job_ctrl.vld;
      out_vld_nxt = v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      v1_r      <= v1_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last1_r           <= job_ctrl.last;
      out_ch.red_even   <= rgb_even.red;
      out_ch.green_even <= rgb_even.green;
      out_ch.blue_even  <= rgb_even.blue;
      out_ch.red_odd    <= rgb_odd.red;
      out_ch.green_odd  <= rgb_odd.green;
      out_ch.blue_odd   <= rgb_odd.blue;
      out_ch.row_last   <= last1_r;
    end
  end

  assign out_ch.valid = out_vld_r;

endmodule

/* src/yuv420_to_rgb_pixel_pair_top.sv */
// Top level of the BT.601 studio-range YUV 4:2:0 to RGB pixel pair converter.
// Depends on yuvrgb_pkg, yuvrgb_if, yuvrgb_front, yuvrgb_lane and yuvrgb_merge.
//
// One pixel pair transaction is accepted per clock while in_ch.ready is high.
// Each pair yields one RGB result pair, except that in smooth mode a pair is
// held until the next pair of the row arrives, so a row-end pair, or a pair
// after a switch to nearest mode, can release two results. Results leave at
// one per clock while out_ch.ready is high; a four-entry job queue absorbs
// the extra one; in_ch.ready falls only while the queue lacks room for two jobs.
// Two pixel lanes (even, odd) each compute products in one stage and sum,
// round and clamp in the next; the merge stage registers both into the
// result. smooth_enable lies at address 0; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module yuv420_to_rgb_pixel_pair_top (
  input  logic                               clk,
  input  logic                               rst_n,
  yuvrgb_in_if.sink                          in_ch,
  yuvrgb_out_if.source                       out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [yuvrgb_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [yuvrgb_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [yuvrgb_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                               pready
);

  logic                  smooth_r, smooth_nxt;
  logic                  reg_sel;
  yuvrgb_pkg::job_t      head;
  yuvrgb_pkg::job_ctrl_t head_ctrl;
  yuvrgb_pkg::rgb_t      rgb_even, rgb_odd;
  logic                  adv;

  assign pready  = 1'b1;
  assign reg_sel = (yuvrgb_pkg::reg_idx_t'(paddr[yuvrgb_pkg::CFG_ADDR_W-1]) ==
                    yuvrgb_pkg::REG_SMOOTH_ENABLE);

  always_comb begin
    smooth_nxt = smooth_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      smooth_nxt = pwdata[0];
    end
    prdata = reg_sel ? yuvrgb_pkg::CFG_DATA_W'(smooth_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= 1'b0;
    end else begin
      smooth_r <= smooth_nxt;
    end
  end

  yuvrgb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .smooth    (smooth_r),
    .in_ch     (in_ch),
    .pop       (adv),
    .head      (head),
    .head_ctrl (head_ctrl)
  );

  yuvrgb_lane u_lane_even (
    .clk (clk),
    .en  (adv),
    .y   (head.luma_even),
    .u   (head.cb_even),
    .v   (head.cr_even),
    .rgb (rgb_even)
  );

  yuvrgb_lane u_lane_odd (
    .clk (clk),
    .en  (adv),
    .y   (head.luma_odd),
    .u   (head.cb_odd),
    .v   (head.cr_odd),
    .rgb (rgb_odd)
  );

  yuvrgb_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_ctrl (head_ctrl),
    .rgb_even (rgb_even),
    .rgb_odd  (rgb_odd),
    .adv      (adv),
    .out_ch   (out_ch)
  );

endmodule

/* bench/yuv420_to_rgb_pixel_pair_top_tb.sv */
// Self-checking testbench for yuv420_to_rgb_pixel_pair_top: random pixel pair rows in both
// chroma modes, checked pair by pair against a BT.601 fixed-point predictor of the block.
// Depends on yuvrgb_pkg, yuvrgb_if and the converter RTL.
module yuv420_to_rgb_pixel_pair_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic [yuvrgb_pkg::PIX_W-1:0] luma_even;
    logic [yuvrgb_pkg::PIX_W-1:0] luma_odd;
    logic [yuvrgb_pkg::PIX_W-1:0] cb_cur;
    logic [yuvrgb_pkg::PIX_W-1:0] cr_cur;
    logic [yuvrgb_pkg::PIX_W-1:0] cb_near;
    logic [yuvrgb_pkg::PIX_W-1:0] cr_near;
    logic                         row_end;
  } pair_item_t;

  typedef struct packed {
    yuvrgb_pkg::rgb_t even;
    yuvrgb_pkg::rgb_t odd;
    logic             last;
  } rgb_pair_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [yuvrgb_pkg::CFG_ADDR_W-1:0] paddr;
  logic [yuvrgb_pkg::CFG_DATA_W-1:0] pwdata;
  logic [yuvrgb_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  yuvrgb_in_if  in_ch();
  yuvrgb_out_if out_ch();

  yuv420_to_rgb_pixel_pair_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pair_item_t pair_q[$];
  rgb_pair_t  rgb_pairs_due[$];

  // predictor state
  logic       smooth_mode = 1'b0;
  logic       pair_held = 1'b0;
  pair_item_t held_pair;

  pair_item_t drv_pair;
  rgb_pair_t  got_pair;
  rgb_pair_t  want_pair;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int in_gap;
  int out_stall;
  int cycle_cnt = 0;
  int mismatch_cnt = 0;
  int pairs_in = 0;
  int results_seen = 0;
  int settings_cnt = 0;
  int double_cnt = 0;
  int flushed_cnt = 0;
  int p;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [yuvrgb_pkg::PIX_W-1:0] clamp_u8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[yuvrgb_pkg::PIX_W-1:0];
  endfunction

  function automatic yuvrgb_pkg::rgb_t ycc_to_rgb(logic [yuvrgb_pkg::PIX_W-1:0] y,
                                                  logic [yuvrgb_pkg::PIX_W-1:0] u,
                                                  logic [yuvrgb_pkg::PIX_W-1:0] v);
    int ys, us, vs;
    yuvrgb_pkg::rgb_t px;
    ys = (int'(y) - yuvrgb_pkg::Y_OFFSET) * yuvrgb_pkg::COEF_Y;
    us = int'(u) - yuvrgb_pkg::C_OFFSET;
    vs = int'(v) - yuvrgb_pkg::C_OFFSET;
    px.red   = clamp_u8((ys + yuvrgb_pkg::COEF_RV * vs + yuvrgb_pkg::ROUND)
                        >>> yuvrgb_pkg::FRAC_W);
    px.green = clamp_u8((ys - yuvrgb_pkg::COEF_GU * us - yuvrgb_pkg::COEF_GV * vs
                         + yuvrgb_pkg::ROUND) >>> yuvrgb_pkg::FRAC_W);
    px.blue  = clamp_u8((ys + yuvrgb_pkg::COEF_BU * us + yuvrgb_pkg::ROUND)
                        >>> yuvrgb_pkg::FRAC_W);
    return px;
  endfunction

  // 3:1 row blend; odd pixel also averages with the next column
  function automatic rgb_pair_t blend_pair(pair_item_t cur, pair_item_t nxt, logic last);
    int ue, ve, uo, vo;
    rgb_pair_t r;
    ue = (3 * int'(cur.cb_cur) + int'(cur.cb_near) + 2) >> 2;
    ve = (3 * int'(cur.cr_cur) + int'(cur.cr_near) + 2) >> 2;
    uo = (3 * int'(cur.cb_cur) + 3 * int'(nxt.cb_cur) + int'(cur.cb_near)
          + int'(nxt.cb_near) + 4) >> 3;
    vo = (3 * int'(cur.cr_cur) + 3 * int'(nxt.cr_cur) + int'(cur.cr_near)
          + int'(nxt.cr_near) + 4) >> 3;
    r.even = ycc_to_rgb(cur.luma_even, 8'(ue), 8'(ve));
    r.odd  = ycc_to_rgb(cur.luma_odd, 8'(uo), 8'(vo));
    r.last = last;
    return r;
  endfunction

  task automatic convert_pair(pair_item_t it);
    rgb_pair_t r;
    if (smooth_mode) begin
      if (pair_held) rgb_pairs_due.push_back(blend_pair(held_pair, it, 1'b0));
      if (it.row_end) begin
        if (pair_held) double_cnt++;
        rgb_pairs_due.push_back(blend_pair(it, it, 1'b1));
        pair_held = 1'b0;
      end else begin
        held_pair = it;
        pair_held = 1'b1;
      end
    end else begin
      if (pair_held) begin
        rgb_pairs_due.push_back(blend_pair(held_pair, held_pair, 1'b0));
        pair_held = 1'b0;
        flushed_cnt++;
      end
      r.even = ycc_to_rgb(it.luma_even, it.cb_cur, it.cr_cur);
      r.odd  = ycc_to_rgb(it.luma_odd, it.cb_cur, it.cr_cur);
      r.last = it.row_end;
      rgb_pairs_due.push_back(r);
    end
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [yuvrgb_pkg::PIX_W-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 24));
      3: return 8'($urandom_range(228, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pair_item_t make_pair(int ye, int yo, int cb, int cr, int cbn, int crn,
                                           logic re);
    pair_item_t it;
    it.luma_even = 8'(ye);
    it.luma_odd  = 8'(yo);
    it.cb_cur    = 8'(cb);
    it.cr_cur    = 8'(cr);
    it.cb_near   = 8'(cbn);
    it.cr_near   = 8'(crn);
    it.row_end   = re;
    return it;
  endfunction

  task automatic check_field(string name, logic [yuvrgb_pkg::PIX_W-1:0] want,
                             logic [yuvrgb_pkg::PIX_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic write_reg(yuvrgb_pkg::reg_idx_t idx, logic val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= yuvrgb_pkg::CFG_ADDR_W'(4 * int'(idx));
    pwdata  <= {31'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == yuvrgb_pkg::REG_SMOOTH_ENABLE) smooth_mode = val;
    settings_cnt++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pair_q.size() != 0 || in_ch.valid || rgb_pairs_due.size() != 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // rows of random length; some rows carry random row_end bits as noise
  task automatic queue_random_rows(int n_items, bit open_end);
    int left, row_len, k;
    bit noisy;
    pair_item_t it;
    left = n_items;
    while (left > 0) begin
      case ($urandom_range(0, 9))
        0: row_len = 1;
        1: row_len = $urandom_range(24, 48);
        default: row_len = $urandom_range(2, 10);
      endcase
      if (row_len > left) row_len = left;
      noisy = ($urandom_range(0, 6) == 0);
      for (k = 0; k < row_len; k++) begin
        it = make_pair(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                       rand_byte(), noisy ? 1'($urandom_range(0, 1)) : (k == row_len - 1));
        left--;
        if (left == 0) it.row_end = !open_end;
        pair_q.push_back(it);
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        convert_pair(drv_pair);
        pairs_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0 || pair_q.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end else begin
          drv_pair = pair_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.luma_even <= drv_pair.luma_even;
          in_ch.luma_odd  <= drv_pair.luma_odd;
          in_ch.cb_cur    <= drv_pair.cb_cur;
          in_ch.cr_cur    <= drv_pair.cr_cur;
          in_ch.cb_near   <= drv_pair.cb_near;
          in_ch.cr_near   <= drv_pair.cr_near;
          in_ch.row_end   <= drv_pair.row_end;
          in_gap = pick_gap(in_calm);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_pair.even = '{out_ch.red_even, out_ch.green_even, out_ch.blue_even};
        got_pair.odd  = '{out_ch.red_odd, out_ch.green_odd, out_ch.blue_odd};
        got_pair.last = out_ch.row_last;
        results_seen++;
        if (rgb_pairs_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, got_pair);
          mismatch_cnt++;
        end else begin
          want_pair = rgb_pairs_due.pop_front();
          check_field("red_even", want_pair.even.red, got_pair.even.red);
          check_field("green_even", want_pair.even.green, got_pair.even.green);
          check_field("blue_even", want_pair.even.blue, got_pair.even.blue);
          check_field("red_odd", want_pair.odd.red, got_pair.odd.red);
          check_field("green_odd", want_pair.odd.green, got_pair.odd.green);
          check_field("blue_odd", want_pair.odd.blue, got_pair.odd.blue);
          check_field("row_last", 8'(want_pair.last), 8'(got_pair.last));
        end
      end
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall--;
      end else begin
        out_ch.ready <= 1'b1;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.luma_even = '0;
    in_ch.luma_odd = '0;
    in_ch.cb_cur = '0;
    in_ch.cr_cur = '0;
    in_ch.cb_near = '0;
    in_ch.cr_near = '0;
    in_ch.row_end = 1'b0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // nearest chroma out of reset: luma and chroma extremes
    pair_q.push_back(make_pair(0, 255, 0, 255, 255, 0, 1'b0));
    pair_q.push_back(make_pair(255, 0, 255, 0, 0, 255, 1'b1));
    pair_q.push_back(make_pair(16, 235, 128, 128, 0, 0, 1'b0));
    pair_q.push_back(make_pair(0, 0, 0, 0, 0, 0, 1'b0));
    pair_q.push_back(make_pair(255, 255, 255, 255, 255, 255, 1'b1));
    wait_idle();

    // smooth: held pairs, row end releasing two, single-pair row
    write_reg(yuvrgb_pkg::REG_SMOOTH_ENABLE, 1'b1);
    pair_q.push_back(make_pair(100, 150, 0, 255, 255, 0, 1'b0));
    pair_q.push_back(make_pair(235, 16, 255, 0, 0, 255, 1'b0));
    pair_q.push_back(make_pair(128, 128, 128, 128, 128, 128, 1'b1));
    pair_q.push_back(make_pair(16, 235, 255, 255, 255, 255, 1'b1));
    pair_q.push_back(make_pair(255, 0, 0, 0, 0, 0, 1'b0));
    pair_q.push_back(make_pair(0, 255, 255, 255, 0, 0, 1'b1));
    pair_q.push_back(make_pair(200, 50, 30, 220, 90, 160, 1'b0));
    wait_idle();

    // switch to nearest while a pair is held
    write_reg(yuvrgb_pkg::REG_SMOOTH_ENABLE, 1'b0);
    pair_q.push_back(make_pair(50, 200, 10, 20, 250, 240, 1'b0));
    pair_q.push_back(make_pair(255, 255, 0, 255, 255, 0, 1'b1));
    wait_idle();

    // rewrite smooth while a pair is held
    write_reg(yuvrgb_pkg::REG_SMOOTH_ENABLE, 1'b1);
    pair_q.push_back(make_pair(70, 80, 255, 0, 0, 255, 1'b0));
    wait_idle();
    write_reg(yuvrgb_pkg::REG_SMOOTH_ENABLE, 1'b1);
    pair_q.push_back(make_pair(180, 20, 0, 255, 255, 0, 1'b1));
    wait_idle();

    for (p = 0; p < 8; p++) begin
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      write_reg(yuvrgb_pkg::REG_SMOOTH_ENABLE,
                (p < 2) ? 1'(p) : 1'($urandom_range(0, 1)));
      queue_random_rows($urandom_range(90, 130), $urandom_range(0, 2) == 0);
      wait_idle();
    end

    repeat (16) @(posedge clk);
    $display("Ran %0d pixel pairs through %0d mode settings, %0d RGB pairs checked",
             pairs_in, settings_cnt, results_seen);
    $display("%0d smooth row ends released two pairs, %0d held pairs flushed by nearest mode",
             double_cnt, flushed_cnt);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
